/* design/sptq_pkg.sv */
// ----------------------------------------------------------------------------
// sptq_pkg
// Shared types and constants for the sorted periodic timer queue.
// ----------------------------------------------------------------------------
`default_nettype none
package sptq_pkg;
  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int TIME_W      = 48;
  localparam int PER_W       = 31;
  localparam int DLY_W       = 31;
  localparam int HND_W       = 8;
  localparam int WAIT_W      = 27;
  localparam int DIV_CNT_W   = $clog2(TIME_W + 1);

  localparam logic [PER_W-1:0]  MIN_PERIOD = PER_W'(20);
  localparam logic [WAIT_W-1:0] WAIT_CAP   = WAIT_W'(24 * 3600 * 1000);
  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_DROP = 2'd2;
  localparam logic [1:0] CMD_FIRE = 2'd3;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_SUM    = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [PER_W-1:0]  period;
    logic [HND_W-1:0]  owner;
  } rec_t;
endpackage
`default_nettype wire

/* design/sptq_rec_ram.sv */
// ----------------------------------------------------------------------------
// sptq_rec_ram
// Per-slot timer record memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sptq_rec_ram
  import sptq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [SLOT_W-1:0] waddr,
  input  wire rec_t              wdata,
  input  wire logic              re,
  input  wire logic [SLOT_W-1:0] raddr,
  output rec_t                   rdata
);
  rec_t mem [TIMER_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* design/sptq_mod_unit.sv */
// ----------------------------------------------------------------------------
// sptq_mod_unit
// Restoring remainder unit: one numerator bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sptq_mod_unit
  import sptq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [TIME_W-1:0] num,
  input  wire logic [PER_W-1:0]  den,
  output logic                   done,
  output logic [PER_W-1:0]       rem
);
  logic                 run_r, run_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    num_r, num_nxt;
  logic [PER_W-1:0]     den_r, den_nxt;
  logic [PER_W-1:0]     rem_r, rem_nxt;
  logic                 done_r, done_nxt;
  logic [PER_W:0]       trial;

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[TIME_W-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
    end else if (run_r) begin
      // shift one bit in, subtract when it fits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = PER_W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = PER_W'(trial);
      end
      num_nxt = num_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(TIME_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

/* design/sorted_periodic_timer_queue.sv */
// ----------------------------------------------------------------------------
// sorted_periodic_timer_queue
// Deadline-ordered table of one-shot and periodic timers.
// ----------------------------------------------------------------------------
// Issue a command by raising start while busy is low. Each result beat is
// shown for exactly one cycle with out_valid high and cannot be held off;
// out_last marks the final beat of a command. Delete completes straight from
// idle. Add walks the ordered list past every live timer ahead of the new
// one. Drop walks every live timer. Fire first counts due timers, reading up
// to the first timer not yet due, then per due timer pops it and, for a
// periodic timer, runs the bit-serial remainder unit and a list walk to
// reinsert it, then reads the head for the summary. The record memory's
// single read port sets the walk speed.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_periodic_timer_queue
  import sptq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [TIME_W-1:0] in_now_ms,
  input  wire logic [HND_W-1:0]  in_handler_id,
  input  wire logic [DLY_W-1:0]  in_delay_ms,
  input  wire logic [PER_W-1:0]  in_period_ms,
  input  wire logic [3:0]        in_slot,
  output logic                   out_valid,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_handler_out,
  output logic [3:0]             out_slot_out,
  output logic                   out_status,
  output logic [WAIT_W-1:0]      out_wait_ms,
  output logic                   out_last
);
  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DUE_RD   = 12'b000000000010,
    S_DUE_CMP  = 12'b000000000100,
    S_POP_CHK  = 12'b000000001000,
    S_POP_EMIT = 12'b000000010000,
    S_DIV      = 12'b000000100000,
    S_INS_RD   = 12'b000001000000,
    S_INS_CMP  = 12'b000010000000,
    S_SUM_RD   = 12'b000100000000,
    S_SUM_EMIT = 12'b001000000000,
    S_DROP_RD  = 12'b010000000000,
    S_DROP_CMP = 12'b100000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   order_r [TIMER_SLOTS];
  logic [SLOT_W-1:0]   order_nxt [TIMER_SLOTS];
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    due_r, due_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [HND_W-1:0]    hnd_r, hnd_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [TIME_W-1:0]   ins_d_r, ins_d_nxt;
  logic [PER_W-1:0]    per_r, per_nxt;
  logic [HND_W-1:0]    own_r, own_nxt;

  // output beat register
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [HND_W-1:0]    ohnd_r, ohnd_nxt;
  logic [SLOT_W-1:0]   oslot_r, oslot_nxt;
  logic                status_r, status_nxt;
  logic [WAIT_W-1:0]   wait_r, wait_nxt;
  logic                last_r, last_nxt;

  // list edit requests
  logic                do_remove, do_insert;
  logic [CNT_W-1:0]    rm_pos, ins_pos;
  logic [SLOT_W-1:0]   ins_val;

  // memory and remainder unit ports
  logic                we, re;
  logic [SLOT_W-1:0]   waddr, raddr;
  rec_t                wdata, rdata;
  logic                div_go, div_done;
  logic [TIME_W-1:0]   div_num;
  logic [PER_W-1:0]    div_den;
  logic [PER_W-1:0]    div_rem;

  // add and delete helpers
  logic [TIMER_SLOTS-1:0] used;
  logic [SLOT_W-1:0]      free_slot;
  logic [TIME_W:0]        add_sum;
  logic [PER_W-1:0]       add_per;
  logic                   del_hit;
  logic [CNT_W-1:0]       del_pos;
  logic [TIME_W:0]        resched;
  logic [TIME_W-1:0]      diff;

  sptq_rec_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  sptq_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .rem   (div_rem)
  );

  // Occupied slots and the lowest free one.
  always_comb begin
    used = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (CNT_W'(i) < live_r) begin
        used[order_r[i]] = 1'b1;
      end
    end
    free_slot = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Position of the slot to delete among the live entries.
  always_comb begin
    del_hit = 1'b0;
    del_pos = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < live_r && {{(CNT_W-SLOT_W){1'b0}}, order_r[i]} ==
          CNT_W'(in_slot)) begin
        del_hit = 1'b1;
        del_pos = CNT_W'(i);
      end
    end
  end

  assign add_sum = {1'b0, in_now_ms} + (TIME_W + 1)'(in_delay_ms);
  assign add_per = (in_period_ms != '0 && in_period_ms < MIN_PERIOD) ?
                   MIN_PERIOD : in_period_ms;
  // now - ((now - d) mod p) + p is the first deadline past now
  assign resched = {1'b0, now_r} - (TIME_W + 1)'(div_rem) + (TIME_W + 1)'(per_r);
  assign diff    = (rdata.deadline > now_r) ? rdata.deadline - now_r : '0;

  // Order list editing: remove shifts the tail up, insert shifts it down.
  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      order_nxt[i] = order_r[i];
      if (do_remove && CNT_W'(i) >= rm_pos && i < TIMER_SLOTS - 1) begin
        order_nxt[i] = order_r[i + 1];
      end
      if (do_insert) begin
        if (CNT_W'(i) == ins_pos) begin
          order_nxt[i] = ins_val;
        end else if (CNT_W'(i) > ins_pos && i > 0) begin
          order_nxt[i] = order_r[i - 1];
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    idx_nxt       = idx_r;
    due_nxt       = due_r;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    hnd_nxt       = hnd_r;
    slot_nxt      = slot_r;
    ins_d_nxt     = ins_d_r;
    per_nxt       = per_r;
    own_nxt       = own_r;
    out_valid_nxt = 1'b0;
    kind_nxt      = kind_r;
    ohnd_nxt      = '0;
    oslot_nxt     = '0;
    status_nxt    = 1'b0;
    wait_nxt      = '0;
    last_nxt      = 1'b1;
    do_remove     = 1'b0;
    do_insert     = 1'b0;
    rm_pos        = '0;
    ins_pos       = idx_r;
    ins_val       = slot_r;
    we            = 1'b0;
    waddr         = slot_r;
    wdata         = '{deadline: ins_d_r, period: per_r, owner: own_r};
    re            = 1'b0;
    raddr         = order_r[idx_r[SLOT_W-1:0]];
    div_go        = 1'b0;
    div_num       = now_r - rdata.deadline;
    div_den       = rdata.period;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd;
          now_nxt = in_now_ms;
          hnd_nxt = in_handler_id;
          idx_nxt = '0;
          unique case (in_cmd)
            CMD_ADD: begin
              if (live_r >= CNT_W'(TIMER_SLOTS)) begin
                // table full: report and change nothing
                out_valid_nxt = 1'b1;
                kind_nxt      = KIND_ADD;
                status_nxt    = 1'b1;
              end else begin
                slot_nxt  = free_slot;
                per_nxt   = add_per;
                own_nxt   = in_handler_id;
                ins_d_nxt = add_sum[TIME_W] ? TIME_MAX : add_sum[TIME_W-1:0];
                we        = 1'b1;
                waddr     = free_slot;
                wdata     = '{deadline: ins_d_nxt, period: add_per,
                              owner: in_handler_id};
                state_nxt = S_INS_RD;
              end
            end
            CMD_DEL: begin
              if (del_hit) begin
                do_remove = 1'b1;
                rm_pos    = del_pos;
                live_nxt  = live_r - 1'b1;
              end
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_DONE;
            end
            CMD_DROP: state_nxt = S_DROP_RD;
            CMD_FIRE: state_nxt = S_DUE_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // count the timers due at now
      S_DUE_RD: begin
        if (idx_r == live_r) begin
          due_nxt   = idx_r;
          state_nxt = S_POP_CHK;
        end else begin
          re        = 1'b1;
          state_nxt = S_DUE_CMP;
        end
      end
      S_DUE_CMP: begin
        if (rdata.deadline <= now_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DUE_RD;
        end else begin
          due_nxt   = idx_r;
          state_nxt = S_POP_CHK;
        end
      end

      // pop the head, read its record
      S_POP_CHK: begin
        if (due_r == '0) begin
          state_nxt = S_SUM_RD;
        end else begin
          re        = 1'b1;
          raddr     = order_r[0];
          slot_nxt  = order_r[0];
          do_remove = 1'b1;
          rm_pos    = '0;
          live_nxt  = live_r - 1'b1;
          due_nxt   = due_r - 1'b1;
          state_nxt = S_POP_EMIT;
        end
      end
      S_POP_EMIT: begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_EXPIRY;
        ohnd_nxt      = rdata.owner;
        oslot_nxt     = slot_r;
        last_nxt      = 1'b0;
        per_nxt       = rdata.period;
        own_nxt       = rdata.owner;
        if (rdata.period != '0) begin
          div_go    = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_POP_CHK;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ins_d_nxt = resched[TIME_W] ? TIME_MAX : resched[TIME_W-1:0];
          we        = 1'b1;
          wdata     = '{deadline: ins_d_nxt, period: per_r, owner: own_r};
          idx_nxt   = '0;
          state_nxt = S_INS_RD;
        end
      end

      // walk past every entry with deadline <= the new one, then insert
      S_INS_RD: begin
        if (idx_r == live_r) begin
          do_insert = 1'b1;
          live_nxt  = live_r + 1'b1;
          if (cmd_r == CMD_ADD) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_ADD;
            oslot_nxt     = slot_r;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_POP_CHK;
          end
        end else begin
          re        = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (rdata.deadline <= ins_d_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          do_insert = 1'b1;
          live_nxt  = live_r + 1'b1;
          if (cmd_r == CMD_ADD) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_ADD;
            oslot_nxt     = slot_r;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_POP_CHK;
          end
        end
      end

      S_SUM_RD: begin
        if (live_r == '0) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_SUM;
          wait_nxt      = WAIT_CAP;
          state_nxt     = S_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = order_r[0];
          state_nxt = S_SUM_EMIT;
        end
      end
      S_SUM_EMIT: begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_SUM;
        wait_nxt      = (diff < TIME_W'(WAIT_CAP)) ? WAIT_W'(diff) : WAIT_CAP;
        state_nxt     = S_IDLE;
      end

      // drop every timer owned by the handler
      S_DROP_RD: begin
        if (idx_r == live_r) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DONE;
          state_nxt     = S_IDLE;
        end else begin
          re        = 1'b1;
          state_nxt = S_DROP_CMP;
        end
      end
      S_DROP_CMP: begin
        if (rdata.owner == hnd_r) begin
          do_remove = 1'b1;
          rm_pos    = idx_r;
          live_nxt  = live_r - 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        state_nxt = S_DROP_RD;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      order_r[i] <= order_nxt[i];
    end
    idx_r    <= idx_nxt;
    due_r    <= due_nxt;
    cmd_r    <= cmd_nxt;
    now_r    <= now_nxt;
    hnd_r    <= hnd_nxt;
    slot_r   <= slot_nxt;
    ins_d_r  <= ins_d_nxt;
    per_r    <= per_nxt;
    own_r    <= own_nxt;
    kind_r   <= kind_nxt;
    ohnd_r   <= ohnd_nxt;
    oslot_r  <= oslot_nxt;
    status_r <= status_nxt;
    wait_r   <= wait_nxt;
    last_r   <= last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_handler_out = ohnd_r;
  assign out_slot_out    = 4'(oslot_r);
  assign out_status      = status_r;
  assign out_wait_ms     = wait_r;
  assign out_last        = last_r;
endmodule
`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted periodic timer queue: directed commands
// then random add/delete/drop/fire traffic, every result beat checked against
// an in-bench model of the deadline-ordered timer table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sptq_pkg::*;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        hnd;
    logic [3:0]        slt;
    logic              st;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } beat_t;

  // Timer table model plus the queue of beats it predicts.
  class timer_scoreboard;
    logic [TIME_W-1:0] deadline[TIMER_SLOTS];
    logic [PER_W-1:0]  period[TIMER_SLOTS];
    logic [7:0]        owner[TIMER_SLOTS];
    int                order[$];
    beat_t             pending[$];
    int                errors;

    function void push_beat(logic [1:0] k, logic [7:0] h, logic [3:0] s, logic st,
                            logic [WAIT_W-1:0] w, logic l);
      beat_t b;
      b.kind = k; b.hnd = h; b.slt = s; b.st = st; b.wait_ms = w; b.last = l;
      pending.push_back(b);
    endfunction

    function void place(int s);
      int pos;
      pos = 0;
      while (pos < order.size() && deadline[order[pos]] <= deadline[s]) pos++;
      order.insert(pos, s);
    endfunction

    function logic [TIME_W-1:0] clamp(logic [TIME_W:0] t);
      return t[TIME_W] ? TIME_MAX : t[TIME_W-1:0];
    endfunction

    function void note_command(logic [1:0] cmd, logic [TIME_W-1:0] now, logic [7:0] h,
                               logic [DLY_W-1:0] dly, logic [PER_W-1:0] per,
                               logic [3:0] sl);
      bit used[TIMER_SLOTS];
      int s, due, i;
      logic [TIME_W-1:0] d, diff;
      logic [63:0] steps, sum;
      logic [WAIT_W-1:0] w;
      case (cmd)
        CMD_ADD: begin
          if (order.size() >= TIMER_SLOTS) begin
            push_beat(KIND_ADD, 0, 0, 1, 0, 1);
            return;
          end
          foreach (order[j]) used[order[j]] = 1;
          s = 0;
          while (used[s]) s++;
          if (per != 0 && per < MIN_PERIOD) per = MIN_PERIOD;
          deadline[s] = clamp({1'b0, now} + dly);
          period[s] = per;
          owner[s] = h;
          place(s);
          push_beat(KIND_ADD, 0, 4'(s), 0, 0, 1);
        end
        CMD_DEL: begin
          foreach (order[j]) if (order[j] == sl) begin
            order.delete(j);
            break;
          end
          push_beat(KIND_DONE, 0, 0, 0, 0, 1);
        end
        CMD_DROP: begin
          i = 0;
          while (i < order.size()) if (owner[order[i]] == h) order.delete(i); else i++;
          push_beat(KIND_DONE, 0, 0, 0, 0, 1);
        end
        default: begin
          due = 0;
          while (due < order.size() && deadline[order[due]] <= now) due++;
          repeat (due) begin
            s = order.pop_front();
            push_beat(KIND_EXPIRY, owner[s], 4'(s), 0, 0, 0);
            if (period[s] != 0) begin
              d = deadline[s];
              steps = (64'(now) - 64'(d)) / 64'(period[s]) + 1;
              sum = 64'(d) + steps * 64'(period[s]);
              deadline[s] = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
              place(s);
            end
          end
          w = WAIT_CAP;
          if (order.size() > 0) begin
            d = deadline[order[0]];
            diff = (d > now) ? d - now : '0;
            if (diff < 48'(WAIT_CAP)) w = diff[WAIT_W-1:0];
          end
          push_beat(KIND_SUM, 0, 0, 0, w, 1);
        end
      endcase
    endfunction

    function void check_beat(beat_t got, realtime t);
      beat_t exp_b;
      if (pending.size() == 0) begin
        $display("%t unexpected beat: kind %0d slot %0d", t, got.kind, got.slt);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (got.kind !== exp_b.kind) begin
        $display("%t kind: expected %0d actual %0d", t, exp_b.kind, got.kind); errors++;
      end
      if (got.hnd !== exp_b.hnd) begin
        $display("%t handler: expected %0d actual %0d", t, exp_b.hnd, got.hnd); errors++;
      end
      if (got.slt !== exp_b.slt) begin
        $display("%t slot: expected %0d actual %0d", t, exp_b.slt, got.slt); errors++;
      end
      if (got.st !== exp_b.st) begin
        $display("%t status: expected %0d actual %0d", t, exp_b.st, got.st); errors++;
      end
      if (got.wait_ms !== exp_b.wait_ms) begin
        $display("%t wait: expected %0d actual %0d", t, exp_b.wait_ms, got.wait_ms);
        errors++;
      end
      if (got.last !== exp_b.last) begin
        $display("%t last: expected %0d actual %0d", t, exp_b.last, got.last); errors++;
      end
    endfunction
  endclass

  logic              clk, rst_n, start, busy;
  logic [1:0]        in_cmd;
  logic [TIME_W-1:0] in_now_ms;
  logic [HND_W-1:0]  in_handler_id;
  logic [DLY_W-1:0]  in_delay_ms;
  logic [PER_W-1:0]  in_period_ms;
  logic [3:0]        in_slot;
  logic              out_valid, out_status, out_last;
  logic [1:0]        out_kind;
  logic [7:0]        out_handler_out;
  logic [3:0]        out_slot_out;
  logic [WAIT_W-1:0] out_wait_ms;

  sorted_periodic_timer_queue dut (.*);

  timer_scoreboard timers;
  logic [TIME_W-1:0] clock_ms;   // running time base for well-formed traffic
  bit   calm;                    // no idling in the closing stretch
  longint cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog: worst case ~17 beats per fire, each periodic one with a remainder and a list walk.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("sorted_periodic_timer_queue: mismatch");
      $finish;
    end
  end

  // Sample result beats at the edge that ends their cycle.
  always @(posedge clk) begin
    beat_t b;
    if (rst_n && out_valid) begin
      b.kind = out_kind; b.hnd = out_handler_out; b.slt = out_slot_out;
      b.st = out_status; b.wait_ms = out_wait_ms; b.last = out_last;
      timers.check_beat(b, $realtime);
    end
  end

  // Issue one command beat; hold start until the block takes it. Start stays
  // high into the next command and drops only for an idle burst.
  task automatic issue(logic [1:0] cmd, logic [TIME_W-1:0] now, logic [7:0] h,
                       logic [DLY_W-1:0] dly, logic [PER_W-1:0] per, logic [3:0] sl);
    if (!calm && $urandom_range(3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1; in_cmd <= cmd; in_now_ms <= now; in_handler_id <= h;
    in_delay_ms <= dly; in_period_ms <= per; in_slot <= sl;
    do @(posedge clk); while (busy);
    timers.note_command(cmd, now, h, dly, per, sl);
  endtask

  // Random command, mostly well-formed: time moves forward, delays modest.
  task automatic random_command();
    int r;
    logic [DLY_W-1:0] dly;
    logic [PER_W-1:0] per;
    r = $urandom_range(99);
    clock_ms = clock_ms + TIME_W'($urandom_range(0, 300));
    case ($urandom_range(9))
      0: dly = DLY_W'($urandom);
      1: dly = 0;
      default: dly = DLY_W'($urandom_range(0, 600));
    endcase
    case ($urandom_range(7))
      0: per = PER_W'($urandom);
      1: per = PER_W'($urandom_range(1, 19));
      2, 3: per = PER_W'($urandom_range(20, 400));
      default: per = 0;
    endcase
    if (r < 40)
      issue(CMD_ADD, clock_ms, HND_W'($urandom_range(0, 7)), dly, per, 4'($urandom));
    else if (r < 50)
      issue(CMD_DEL, clock_ms, HND_W'($urandom), DLY_W'($urandom), PER_W'($urandom),
            4'($urandom));
    else if (r < 56)
      issue(CMD_DROP, clock_ms, HND_W'($urandom_range(0, 9)), DLY_W'($urandom),
            PER_W'($urandom), 4'($urandom));
    else if (r < 58)
      issue(CMD_ADD, TIME_W'({$urandom, $urandom}), HND_W'($urandom), DLY_W'($urandom),
            PER_W'($urandom), 4'($urandom));
    else
      issue(CMD_FIRE, clock_ms, HND_W'($urandom), DLY_W'($urandom), PER_W'($urandom),
            4'($urandom));
  endtask

  initial begin
    timers = new();
    cycles = 0;
    calm = 0;
    clock_ms = 1000;
    rst_n = 0; start = 0; in_cmd = CMD_FIRE; in_now_ms = 0; in_handler_id = 0;
    in_delay_ms = 0; in_period_ms = 0; in_slot = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty fire, short period, extremes, far deadlines, delete, drop, full table.
    issue(CMD_FIRE, 0, 0, 0, 0, 0);
    issue(CMD_ADD, 100, 8'hFF, 0, 1, 4'hF);
    issue(CMD_ADD, 100, 8'h00, 10, 0, 0);
    issue(CMD_ADD, TIME_MAX, 8'hA5, {DLY_W{1'b1}}, {PER_W{1'b1}}, 0);
    issue(CMD_ADD, TIME_MAX - 5, 8'h5A, 0, 7, 0);
    issue(CMD_FIRE, 100, 0, 0, 0, 0);
    issue(CMD_FIRE, 175, 0, 0, 0, 0);
    issue(CMD_FIRE, TIME_MAX, 0, 0, 0, 0);
    issue(CMD_FIRE, TIME_MAX, 0, 0, 0, 0);
    issue(CMD_DEL, 0, 0, 0, 0, 4'hF);
    issue(CMD_DROP, 0, 8'h77, 0, 0, 0);
    issue(CMD_DROP, 0, 8'hA5, 0, 0, 0);
    issue(CMD_DROP, 0, 8'h5A, 0, 0, 0);
    issue(CMD_DROP, 0, 8'hFF, 0, 0, 0);
    for (int i = 0; i < 17; i++) issue(CMD_ADD, 2000, 8'(i), DLY_W'(100 * i), 0, 0);
    issue(CMD_DEL, 0, 0, 0, 0, 4'd3);
    issue(CMD_FIRE, 100_000_000, 0, 0, 0, 0);
    issue(CMD_FIRE, 100_000_000, 0, 0, 0, 0);

    for (int n = 0; n < 235; n++) begin
      if (n > 200) calm = 1;
      random_command();
    end
    start <= 0;

    // Drain: wait for outstanding beats, then a settling margin.
    while (timers.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (timers.errors == 0)
      $display("sorted_periodic_timer_queue: match");
    else
      $display("sorted_periodic_timer_queue: mismatch");
    $finish;
  end
endmodule

/* sim.f */
design/sptq_pkg.sv
design/sptq_rec_ram.sv
design/sptq_mod_unit.sv
design/sorted_periodic_timer_queue.sv
verif/tb.sv
